[src/lcs_pkg.sv]
// shared types and constants for the longest common subsequence length engine
package lcs_pkg;

    localparam int unsigned LEN_W = 9;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_FEED   = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] symbol;
    } in_t;

    typedef struct packed {
        logic [LEN_W-1:0] lcs_length;
        logic             overflow;
    } out_t;

    typedef struct packed {
        logic             tok_valid;
        logic [1:0]       req;
        logic [7:0]       sym;
        logic [LEN_W-1:0] score_new;
        logic [LEN_W-1:0] score_old;
    } link_t;

endpackage

[src/lcs_engine.sv]
// top level of the longest common subsequence length engine
//
// Longest common subsequence length of two byte strings, computed by a systolic
// chain of MAX_LEN cells, one per reference byte. Every request (load reference
// byte, feed text byte, finish) enters the chain as a token and moves one cell per
// cycle while no result is stalled, and the block takes one request per cycle
// under that condition. A finish request's result passes through all MAX_LEN
// cell registers and then the result register. A stalled result stops the whole
// chain and holds s_ready low until it is taken. Reference bytes beyond MAX_LEN set
// the overflow flag reported with the next result; lengths above 511 saturate.
module lcs_length_engine #(
    parameter int unsigned MAX_LEN = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lcs_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lcs_pkg::out_t m_data
);

    lcs_pkg::link_t link_w [MAX_LEN+1];
    logic           advance;

    assign s_ready = advance;

    always_comb begin
        link_w[0].tok_valid = s_valid;
        link_w[0].req       = s_data.req_type;
        link_w[0].sym       = s_data.symbol;
        link_w[0].score_new = '0;
        link_w[0].score_old = '0;
    end

    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        lcs_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .in_link  (link_w[i]),
            .out_link (link_w[i+1])
        );
    end

    lcs_tail u_tail (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_link (link_w[MAX_LEN]),
        .advance (advance),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[src/lcs_cell.sv]
// one column of the score row: holds a reference byte and its score
module lcs_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          advance,
    input  lcs_pkg::link_t in_link,
    output lcs_pkg::link_t out_link
);

    logic                      ref_valid_reg, ref_valid_next;
    logic [7:0]                ref_sym_reg, ref_sym_next;
    logic [lcs_pkg::LEN_W-1:0] score_reg, score_next;
    logic [lcs_pkg::LEN_W-1:0] feed_score;
    lcs_pkg::link_t            out_link_reg, out_link_next;

    always_comb begin
        if (ref_valid_reg && (ref_sym_reg == in_link.sym)) begin
            feed_score = (in_link.score_old == lcs_pkg::LEN_MAX) ? lcs_pkg::LEN_MAX
                                                                 : in_link.score_old + 1'b1;
        end else begin
            feed_score = (score_reg > in_link.score_new) ? score_reg : in_link.score_new;
        end
    end

    always_comb begin
        ref_valid_next = ref_valid_reg;
        ref_sym_next   = ref_sym_reg;
        score_next     = score_reg;
        out_link_next  = in_link;
        if (in_link.tok_valid) begin
            case (in_link.req)
                lcs_pkg::REQ_LOAD: begin
                    if (!ref_valid_reg) begin
                        ref_valid_next          = 1'b1;
                        ref_sym_next            = in_link.sym;
                        out_link_next.tok_valid = 1'b0;
                    end
                end
                lcs_pkg::REQ_FEED: begin
                    score_next              = feed_score;
                    out_link_next.score_new = feed_score;
                    out_link_next.score_old = score_reg;
                end
                lcs_pkg::REQ_FINISH: begin
                    out_link_next.score_new = score_reg;
                    ref_valid_next          = 1'b0;
                    score_next              = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_valid_reg          <= 1'b0;
            score_reg              <= '0;
            out_link_reg.tok_valid <= 1'b0;
        end else if (advance) begin
            ref_valid_reg <= ref_valid_next;
            score_reg     <= score_next;
            out_link_reg  <= out_link_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ref_sym_reg <= ref_sym_next;
        end
    end

    assign out_link = out_link_reg;

`ifndef ASSERT_OFF
    // a reference byte is only dropped by a finish request
    a_ref_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && in_link.tok_valid && (in_link.req == lcs_pkg::REQ_FINISH))
        |=> !$fell(ref_valid_reg))
        else $error("reference byte lost without finish");

    // scores never shrink within one string pair
    a_score_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && in_link.tok_valid && (in_link.req == lcs_pkg::REQ_FINISH))
        |=> score_reg >= $past(score_reg))
        else $error("score decreased");

    // a text byte raises a column at most one above its left neighbor
    a_score_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_link.tok_valid && (in_link.req == lcs_pkg::REQ_FEED)
        |=> {1'b0, score_reg} <= {1'b0, $past(in_link.score_new)} + 1'b1)
        else $error("score step too large");
`endif

endmodule

[src/lcs_tail.sv]
// end of the chain: overflow tracking and result register
module lcs_tail (
    input  logic          aclk,
    input  logic          aresetn,
    input  lcs_pkg::link_t in_link,
    output logic          advance,
    output logic          m_valid,
    input  logic          m_ready,
    output lcs_pkg::out_t m_data
);

    logic          out_valid_reg, out_valid_next;
    logic          overflow_reg, overflow_next;
    lcs_pkg::out_t out_data_reg;
    logic          finish_tok;
    logic          load_tok;

    assign advance    = !out_valid_reg || m_ready;
    assign finish_tok = in_link.tok_valid && (in_link.req == lcs_pkg::REQ_FINISH);
    assign load_tok   = in_link.tok_valid && (in_link.req == lcs_pkg::REQ_LOAD);

    always_comb begin
        out_valid_next = out_valid_reg;
        overflow_next  = overflow_reg;
        if (advance) begin
            out_valid_next = finish_tok;
            if (finish_tok) begin
                overflow_next = 1'b0;
            end else if (load_tok) begin
                overflow_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            overflow_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            overflow_reg  <= overflow_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && finish_tok) begin
            out_data_reg.lcs_length <= in_link.score_new;
            out_data_reg.overflow   <= overflow_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef ASSERT_OFF
    // overflow belongs to one string pair only
    a_ovf_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && finish_tok |=> !overflow_reg && out_valid_reg)
        else $error("overflow not cleared on finish");
`endif

endmodule

[tb/sv/lcs_length_checker.sv]
// request and result monitor with lcs length prediction and result comparison
module lcs_length_checker #(
    parameter int unsigned MAX_LEN = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  lcs_pkg::in_t  s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  lcs_pkg::out_t m_data,
    output int            fail_count,
    output int            pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import lcs_pkg::*;

    logic [7:0]  held_syms [MAX_LEN];
    int unsigned held_len;
    int unsigned score_row [MAX_LEN+1];
    logic        ovf_seen;
    out_t        expected_results [$];

    task automatic clear_pair();
        for (int k = 0; k <= MAX_LEN; k++) begin
            score_row[k] = 0;
        end
        held_len = 0;
        ovf_seen = 1'b0;
    endtask

    task automatic advance_lcs(input in_t rq);
        int unsigned diag;
        int unsigned up;
        int unsigned left;
        int unsigned nxt;
        out_t        res;
        case (rq.req_type)
            REQ_LOAD: begin
                if (held_len >= MAX_LEN) begin
                    ovf_seen = 1'b1;
                end else begin
                    held_syms[held_len] = rq.symbol;
                    held_len++;
                    score_row[held_len] = score_row[held_len-1];
                end
            end
            REQ_FEED: begin
                diag = 0;
                for (int j = 1; j <= held_len; j++) begin
                    up = score_row[j];
                    left = score_row[j-1];
                    if (held_syms[j-1] == rq.symbol) begin
                        nxt = diag + 1;
                    end else begin
                        nxt = (up > left) ? up : left;
                    end
                    diag = up;
                    score_row[j] = nxt;
                end
            end
            REQ_FINISH: begin
                if (score_row[held_len] > LEN_MAX) begin
                    res.lcs_length = LEN_MAX;
                end else begin
                    res.lcs_length = LEN_W'(score_row[held_len]);
                end
                res.overflow = ovf_seen;
                expected_results.push_back(res);
                clear_pair();
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin : watch
        out_t want;
        if (!aresetn) begin
            clear_pair();
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request waiting: lcs_length %0d overflow %0d",
                           m_data.lcs_length, m_data.overflow);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.lcs_length !== want.lcs_length) begin
                        $error("lcs_length: expected %0d, actual %0d",
                               want.lcs_length, m_data.lcs_length);
                        fail_count++;
                    end
                    if (m_data.overflow !== want.overflow) begin
                        $error("overflow: expected %0d, actual %0d",
                               want.overflow, m_data.overflow);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                advance_lcs(s_data);
            end
        end
        pending_count = expected_results.size();
    end

endmodule

[tb/sv/tb_lcs_length_engine.sv]
// testbench top for the lcs length engine: clock, reset, request stimulus and verdict
module tb_lcs_length_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import lcs_pkg::*;

    localparam int unsigned ROW_CAP       = 256;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned TAIL_CYCLES   = 300;
    localparam int unsigned HOLD_CYCLES   = 1500;
    localparam int unsigned ITEM_TARGET   = 1200;
    localparam logic [1:0]  REQ_UNUSED    = 2'd3;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    in_t   s_data = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    out_t  m_data;
    int    fail_count;
    int    pending_count;
    bit    steady = 1'b0;
    bit    hold_off_req = 1'b0;
    int unsigned item_count = 0;
    int unsigned finish_count = 0;
    int unsigned cycle_count = 0;

    lcs_length_engine #(
        .MAX_LEN(ROW_CAP)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    lcs_length_checker #(
        .MAX_LEN(ROW_CAP)
    ) u_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .fail_count(fail_count),
        .pending_count(pending_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random back-pressure, one long hold-off
    initial begin
        int unsigned stall_left;
        bit          hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 22);
            end
        end
    end

    task automatic send(input logic [1:0] kind, input logic [7:0] sym);
        in_t item;
        item.req_type = kind;
        item.symbol = sym;
        while (!steady && $urandom_range(99) < 22) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (kind != REQ_UNUSED) begin
            item_count++;
        end
        if (kind == REQ_FINISH) begin
            finish_count++;
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0) begin
            @(negedge aclk);
        end
    endtask

    // one reference/text pair ending in a finish request
    task automatic random_pair();
        int unsigned pick;
        int unsigned loads_left;
        int unsigned feeds_left;
        int unsigned span;
        logic [7:0]  base;
        bit          mixed;
        bit          do_load;
        pick = $urandom_range(99);
        if (pick < 70) begin
            loads_left = $urandom_range(12);
        end else if (pick < 92) begin
            loads_left = $urandom_range(40, 13);
        end else if (pick < 98) begin
            loads_left = $urandom_range(200, 41);
        end else begin
            loads_left = $urandom_range(ROW_CAP + 6, ROW_CAP);
        end
        pick = $urandom_range(99);
        if (pick < 75) begin
            feeds_left = $urandom_range(14);
        end else if (pick < 95) begin
            feeds_left = $urandom_range(40, 15);
        end else begin
            feeds_left = $urandom_range(120, 41);
        end
        case ($urandom_range(4))
            0: span = 1;
            1: span = 2;
            2: span = 4;
            3: span = 16;
            default: span = 256;
        endcase
        base = 8'($urandom_range(255));
        mixed = ($urandom_range(99) < 15);
        while (loads_left + feeds_left > 0) begin
            if ($urandom_range(99) < 4) begin
                send(REQ_UNUSED, 8'($urandom_range(255)));
            end
            if (loads_left == 0) begin
                do_load = 1'b0;
            end else if (!mixed || feeds_left == 0) begin
                do_load = 1'b1;
            end else begin
                do_load = 1'($urandom_range(1));
            end
            if (do_load) begin
                loads_left--;
                send(REQ_LOAD, 8'(base + $urandom_range(span - 1)));
            end else begin
                feeds_left--;
                send(REQ_FEED, 8'(base + $urandom_range(span - 1)));
            end
        end
        send(REQ_FINISH, 8'($urandom_range(255)));
    endtask

    initial begin
        bit paused;
        paused = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // empty pair, ignored request code, finish symbol ignored
        send(REQ_FINISH, 8'h00);
        send(REQ_UNUSED, 8'hFF);
        send(REQ_FINISH, 8'hFF);
        // symbol extremes
        send(REQ_LOAD, 8'h00);
        send(REQ_LOAD, 8'hFF);
        send(REQ_FEED, 8'hFF);
        send(REQ_FEED, 8'h00);
        send(REQ_FINISH, 8'h00);
        // text before reference, reference bytes loaded after text
        send(REQ_FEED, 8'h55);
        send(REQ_LOAD, 8'h55);
        send(REQ_FEED, 8'hAA);
        send(REQ_LOAD, 8'h12);
        send(REQ_FEED, 8'h34);
        send(REQ_LOAD, 8'h34);
        send(REQ_FEED, 8'h34);
        send(REQ_FEED, 8'h55);
        send(REQ_FINISH, 8'h00);
        // unused code between load and feed leaves state alone
        send(REQ_LOAD, 8'hA5);
        send(REQ_UNUSED, 8'hA5);
        send(REQ_FEED, 8'hA5);
        send(REQ_FINISH, 8'h5A);
        drain();

        // full reference with dropped bytes and the longest possible match
        steady = 1'b1;
        for (int i = 0; i < ROW_CAP + 3; i++) begin
            send(REQ_LOAD, 8'(i));
        end
        for (int i = 0; i < ROW_CAP; i++) begin
            send(REQ_FEED, 8'(i));
        end
        send(REQ_FINISH, 8'h00);
        send(REQ_FINISH, 8'h00);
        steady = 1'b0;
        drain();

        while (item_count < ITEM_TARGET) begin
            random_pair();
            if (!paused && item_count > 900) begin
                paused = 1'b1;
                drain();
            end
            if (item_count > 1100) begin
                hold_off_req = 1'b1;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
